FILE: rtl/core/gapless_xdrop_extension_defines.svh
// Assertion macros for the gapless X-drop extension block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef GAPLESS_XDROP_EXTENSION_DEFINES_SVH
`define GAPLESS_XDROP_EXTENSION_DEFINES_SVH

`ifndef SYNTH

// Condition holds in the same cycle as the trigger.
`define GXE_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("gxe assertion failed");

// Condition holds in the cycle after the trigger.
`define GXE_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("gxe assertion failed");

`else

`define GXE_ASSERT_SAME(label, trig, cond)
`define GXE_ASSERT_NEXT(label, trig, cond)

`endif

`endif

FILE: rtl/core/gxe_pkg.sv
package gxe_pkg;

  // Widths of the score and length datapaths
  localparam int SCORE_BITS  = 24;
  localparam int LENGTH_BITS = 20;
  localparam int DROP_BITS   = SCORE_BITS - 1;
  // Working width: one sign bit and one carry bit over the score
  localparam int WIDE_BITS   = SCORE_BITS + 2;
  localparam int PS_BITS     = 8;
  localparam int IDX_BITS    = 2;

  localparam logic signed [WIDE_BITS-1:0] SCORE_MAX =
    WIDE_BITS'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE_BITS-1:0] SCORE_MIN = -SCORE_MAX - WIDE_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_MODE     = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_MAX_DROP = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_TARGET   = 2'd2;

  typedef enum logic [1:0] {
    MODE_XDROP      = 2'd0,
    MODE_END_SEARCH = 2'd1,
    MODE_OPT_CHECK  = 2'd2,
    MODE_SUM        = 2'd3
  } mode_t;

  // Clamp a wide sum to the signed score range
  function automatic logic signed [SCORE_BITS-1:0] sat_score(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] c;
    c = v;
    if (v > SCORE_MAX) c = SCORE_MAX;
    if (v < SCORE_MIN) c = SCORE_MIN;
    return SCORE_BITS'(c);
  endfunction

  // Flag a wide sum that falls outside the score range
  function automatic logic sat_hit(input logic signed [WIDE_BITS-1:0] v);
    return (v > SCORE_MAX) || (v < SCORE_MIN);
  endfunction

endpackage

FILE: rtl/core/gapless_xdrop_extension.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_pair_score, in_last
// out      output     out_valid / out_ready  out_done_res, out_result_score, out_length,
//                                            out_verdict_ok, out_overflow
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One result per item, one item per cycle unless out_ready stalls it; the input register
// takes the item at acceptance and the add, compare and clamp load the result register
// as the item leaves it and out_valid rises. The running state updates at the same time.
// Reset is synchronous (rst_n low) and clears handshake, configuration and running state.
// A stalled out channel holds the result; one further item waits in the input register,
// then in_ready drops. cfg_ready is always high.
`include "gapless_xdrop_extension_defines.svh"

module gapless_xdrop_extension (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [gxe_pkg::PS_BITS-1:0]     in_pair_score,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_done_res,
  output logic signed [gxe_pkg::SCORE_BITS-1:0]  out_result_score,
  output logic [gxe_pkg::LENGTH_BITS-1:0]        out_length,
  output logic                                   out_verdict_ok,
  output logic                                   out_overflow,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gxe_pkg::IDX_BITS-1:0]           cfg_index,
  input  logic [gxe_pkg::SCORE_BITS-1:0]         cfg_data
);

  localparam int SW = gxe_pkg::SCORE_BITS;
  localparam int LW = gxe_pkg::LENGTH_BITS;
  localparam int WW = gxe_pkg::WIDE_BITS;

  // Configuration
  gxe_pkg::mode_t                  mode_r;
  logic [gxe_pkg::DROP_BITS-1:0]   max_drop_r;
  logic signed [SW-1:0]            target_r;

  // Input register
  logic                            stage_valid_r;
  logic signed [gxe_pkg::PS_BITS-1:0] stage_ps_r;
  logic                            stage_last_r;
  logic                            stage_adv;

  // Running state
  logic signed [SW-1:0] running_r, running_nxt;
  logic signed [SW-1:0] drop_r, drop_nxt;
  logic signed [SW-1:0] best_r, best_nxt;
  logic [LW-1:0]        count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;

  // Result register
  logic                 out_valid_r;
  logic                 out_done_r, done_c;
  logic signed [SW-1:0] out_score_r, score_c;
  logic [LW-1:0]        out_len_r, len_c;
  logic                 out_ok_r, ok_c;
  logic                 out_ovf_r, ovf_c;

  // Working values
  logic signed [WW-1:0] ps_w, lim_w, d_w, sum_w, grow_w;
  logic signed [SW-1:0] run_sat;
  logic [LW-1:0]        count_inc;

  assign cfg_ready = 1'b1;
  assign stage_adv = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stage_valid_r || stage_adv;

  // Write configuration registers; an unused index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= gxe_pkg::MODE_XDROP;
      max_drop_r <= '0;
      target_r   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == gxe_pkg::REG_MODE) begin
        mode_r <= gxe_pkg::mode_t'(cfg_data[1:0]);
      end else if (cfg_index == gxe_pkg::REG_MAX_DROP) begin
        max_drop_r <= cfg_data[gxe_pkg::DROP_BITS-1:0];
      end else if (cfg_index == gxe_pkg::REG_TARGET) begin
        target_r <= $signed(cfg_data);
      end
    end
  end

  // Hold the accepted item until the result register can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid_r <= 1'b1;
    end else if (stage_adv) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_ps_r   <= in_pair_score;
      stage_last_r <= in_last;
    end
  end

  // Shared arithmetic for the item in the input register
  always_comb begin
    ps_w      = WW'(stage_ps_r);
    lim_w     = WW'(max_drop_r);
    d_w       = WW'(drop_r) - ps_w;
    sum_w     = WW'(running_r) + ps_w;
    grow_w    = WW'(best_r) - d_w;
    run_sat   = gxe_pkg::sat_score(sum_w);
    count_inc = (count_r == gxe_pkg::LEN_MAX) ? count_r : count_r + LW'(1);
  end

  // Step the selected mode and form the result
  always_comb begin
    running_nxt = running_r;
    drop_nxt    = drop_r;
    best_nxt    = best_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    done_c      = 1'b0;
    score_c     = '0;
    len_c       = '0;
    ok_c        = 1'b0;

    unique case (mode_r)
      gxe_pkg::MODE_XDROP: begin
        if (d_w < 0) begin
          best_nxt = gxe_pkg::sat_score(grow_w);
          ovf_nxt  = ovf_r | gxe_pkg::sat_hit(grow_w);
          drop_nxt = '0;
        end else if (d_w > lim_w) begin
          done_c  = 1'b1;
          score_c = best_r;
        end else begin
          drop_nxt = SW'(d_w);
        end
      end
      gxe_pkg::MODE_END_SEARCH: begin
        // A target already reached ends without consuming the item
        if (running_r >= target_r) begin
          done_c = 1'b1;
          len_c  = count_r;
        end else begin
          running_nxt = run_sat;
          ovf_nxt     = ovf_r | gxe_pkg::sat_hit(sum_w);
          count_nxt   = count_inc;
          if (run_sat >= target_r) begin
            done_c = 1'b1;
            len_c  = count_inc;
          end
        end
      end
      gxe_pkg::MODE_OPT_CHECK: begin
        running_nxt = run_sat;
        ovf_nxt     = ovf_r | gxe_pkg::sat_hit(sum_w);
        if (run_sat > best_r) begin
          best_nxt = run_sat;
          if (stage_last_r) begin
            done_c = 1'b1;
            ok_c   = 1'b1;
          end
        end else if ((run_sat <= 0) || stage_last_r ||
                     (WW'(run_sat) < (WW'(best_r) - lim_w))) begin
          done_c = 1'b1;
        end
      end
      gxe_pkg::MODE_SUM: begin
        running_nxt = run_sat;
        ovf_nxt     = ovf_r | gxe_pkg::sat_hit(sum_w);
        if (stage_last_r) begin
          done_c  = 1'b1;
          score_c = run_sat;
        end
      end
      default: begin
        done_c = 1'b0;
      end
    endcase

    ovf_c = ovf_nxt;

    // Clear everything once the extension ends
    if (done_c) begin
      running_nxt = '0;
      drop_nxt    = '0;
      best_nxt    = '0;
      count_nxt   = '0;
      ovf_nxt     = 1'b0;
    end
  end

  // Advance the running state as the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      drop_r    <= '0;
      best_r    <= '0;
      count_r   <= '0;
      ovf_r     <= 1'b0;
    end else if (stage_adv) begin
      running_r <= running_nxt;
      drop_r    <= drop_nxt;
      best_r    <= best_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      out_done_r  <= done_c;
      out_score_r <= score_c;
      out_len_r   <= len_c;
      out_ok_r    <= ok_c;
      out_ovf_r   <= ovf_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_done_res     = out_done_r;
  assign out_result_score = out_score_r;
  assign out_length       = out_len_r;
  assign out_verdict_ok   = out_ok_r;
  assign out_overflow     = out_ovf_r;

  // Checks
  `GXE_ASSERT_NEXT(a_clear_after_done, stage_adv && done_c,
    (running_r == 0) && (best_r == 0) && (drop_r == 0) && (count_r == 0) && !ovf_r)
  `GXE_ASSERT_SAME(a_quiet_fields, out_valid && !out_done_res,
    (out_result_score == 0) && (out_length == 0) && !out_verdict_ok)
  `GXE_ASSERT_SAME(a_stall_cause, !in_ready, stage_valid_r && out_valid_r && !out_ready)

endmodule

FILE: verif/gapless_xdrop_extension_test.sv
`timescale 1ns / 100ps

module gapless_xdrop_extension_test;
  import gxe_pkg::*;

  localparam int CYCLE_LIMIT = 40_000;
  localparam int LOUD_FAULTS = 40;
  // Index past the last register: the block must ignore writes to it
  localparam logic [IDX_BITS-1:0] REG_SPARE = 2'd3;

  typedef logic signed [SCORE_BITS+1:0] wide_t;
  localparam wide_t SCORE_TOP   = wide_t'(2 ** (SCORE_BITS - 1) - 1);
  localparam wide_t SCORE_FLOOR = -SCORE_TOP - 1;

  typedef struct {
    logic signed [PS_BITS-1:0] score;
    logic                      last;
  } residue_t;

  typedef struct {
    logic                         done;
    logic signed [SCORE_BITS-1:0] score;
    logic [LENGTH_BITS-1:0]       len;
    logic                         ok;
    logic                         ovf;
  } outcome_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [PS_BITS-1:0]    in_pair_score = '0;
  logic                         in_last = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_done_res;
  logic signed [SCORE_BITS-1:0] out_result_score;
  logic [LENGTH_BITS-1:0]       out_length;
  logic                         out_verdict_ok;
  logic                         out_overflow;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [IDX_BITS-1:0]          cfg_index = '0;
  logic [SCORE_BITS-1:0]        cfg_data = '0;

  gapless_xdrop_extension dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Settings as the block should hold them
  mode_t                        set_mode = MODE_XDROP;
  logic [DROP_BITS-1:0]         set_drop = '0;
  logic signed [SCORE_BITS-1:0] set_target = '0;

  // Extension state as the block should hold it
  logic signed [SCORE_BITS-1:0] run_sum = '0;
  logic signed [SCORE_BITS-1:0] drop_amt = '0;
  logic signed [SCORE_BITS-1:0] best = '0;
  logic [LENGTH_BITS-1:0]       n_items = '0;
  logic                         ovf_seen = 1'b0;

  residue_t send_queue[$];
  outcome_t predicted[$];
  residue_t nxt_item;
  outcome_t want;
  logic     calm = 1'b0;
  int       faults = 0;
  int       cycles = 0;

  // Clamp to the signed score range, noting any saturation
  function automatic logic signed [SCORE_BITS-1:0] clamp_score(input wide_t v);
    if (v > SCORE_TOP) begin
      ovf_seen = 1'b1;
      return SCORE_TOP[SCORE_BITS-1:0];
    end
    if (v < SCORE_FLOOR) begin
      ovf_seen = 1'b1;
      return SCORE_FLOOR[SCORE_BITS-1:0];
    end
    return v[SCORE_BITS-1:0];
  endfunction

  // Advance the extension by one position score and give its result
  function automatic outcome_t extend_one(input logic signed [PS_BITS-1:0] ps,
                                          input logic last);
    outcome_t r;
    wide_t    p;
    wide_t    lim;
    wide_t    d;
    wide_t    acc;
    r.done  = 1'b0;
    r.score = '0;
    r.len   = '0;
    r.ok    = 1'b0;
    p   = wide_t'(ps);
    lim = wide_t'(set_drop);
    case (set_mode)
      MODE_XDROP: begin
        d = wide_t'(drop_amt);
        d = d - p;
        if (d < 0) begin
          acc = wide_t'(best);
          best = clamp_score(acc - d);
          drop_amt = '0;
        end else if (d > lim) begin
          r.done  = 1'b1;
          r.score = best;
        end else begin
          drop_amt = d[SCORE_BITS-1:0];
        end
      end
      MODE_END_SEARCH: begin
        // a target already met ends the search without taking the item
        if (run_sum >= set_target) begin
          r.done = 1'b1;
          r.len  = n_items;
        end else begin
          acc = wide_t'(run_sum);
          run_sum = clamp_score(acc + p);
          if (~&n_items) n_items = n_items + LENGTH_BITS'(1);
          if (run_sum >= set_target) begin
            r.done = 1'b1;
            r.len  = n_items;
          end
        end
      end
      MODE_OPT_CHECK: begin
        acc = wide_t'(run_sum);
        run_sum = clamp_score(acc + p);
        acc = wide_t'(best);
        acc = acc - lim;
        if (run_sum > best) begin
          best = run_sum;
          if (last) begin
            r.done = 1'b1;
            r.ok   = 1'b1;
          end
        end else if (run_sum <= 0 || last || run_sum < acc) begin
          r.done = 1'b1;
        end
      end
      default: begin
        acc = wide_t'(run_sum);
        run_sum = clamp_score(acc + p);
        if (last) begin
          r.done  = 1'b1;
          r.score = run_sum;
        end
      end
    endcase
    r.ovf = ovf_seen;
    if (r.done) begin
      run_sum  = '0;
      drop_amt = '0;
      best     = '0;
      n_items  = '0;
      ovf_seen = 1'b0;
    end
    return r;
  endfunction

  // Present items from the queue; predict each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted.push_back(extend_one(in_pair_score, in_last));
      if (!in_valid || in_ready) begin
        if (send_queue.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
          nxt_item = send_queue.pop_front();
          in_pair_score <= nxt_item.score;
          in_last       <= nxt_item.last;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input longint exp_val, input longint got);
    if (exp_val != got) begin
      faults++;
      if (faults <= LOUD_FAULTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, exp_val, got);
    end
  endtask

  // Stall the result side at random; compare each result with the oldest prediction
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 21);
    if (rst_n && out_valid && out_ready) begin
      if (predicted.size() == 0) begin
        faults++;
        if (faults <= LOUD_FAULTS)
          $display("%0t: result with none expected, actual done_res %0d score %0d",
                   $time, out_done_res, out_result_score);
      end else begin
        want = predicted.pop_front();
        check_field("done_res", longint'(want.done), longint'(out_done_res));
        check_field("result_score", longint'(want.score), longint'(out_result_score));
        check_field("length", longint'(want.len), longint'(out_length));
        check_field("verdict_ok", longint'(want.ok), longint'(out_verdict_ok));
        check_field("overflow", longint'(want.ovf), longint'(out_overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_item(input int ps, input logic last);
    residue_t it;
    it.score = PS_BITS'(ps);
    it.last  = last;
    send_queue.push_back(it);
  endtask

  // Hold until every queued item has gone through and its result has come back
  task automatic wait_idle();
    while (send_queue.size() != 0 || in_valid || predicted.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write
  task automatic cfg_put(input logic [IDX_BITS-1:0] idx, input logic [SCORE_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:     set_mode = mode_t'(data[1:0]);
      REG_MAX_DROP: set_drop = data[DROP_BITS-1:0];
      REG_TARGET:   set_target = data;
      default: ;
    endcase
  endtask

  // Write every register, with random bits above the mode and drop fields and a random spare write
  task automatic set_config(input mode_t m, input logic [DROP_BITS-1:0] drop,
                            input logic [SCORE_BITS-1:0] tgt);
    logic [31:0] junk;
    junk = $urandom();
    cfg_put(REG_MODE, {junk[SCORE_BITS-1:2], m});
    cfg_put(REG_MAX_DROP, {junk[0], drop});
    cfg_put(REG_TARGET, tgt);
    cfg_put(REG_SPARE, junk[SCORE_BITS-1:0]);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [PS_BITS-1:0] rand_score();
    case ($urandom_range(3))
      0: return PS_BITS'($urandom());
      1: return PS_BITS'($urandom_range(1, 127));
      2: return PS_BITS'($urandom_range(0, 20) - 10);
      default: return PS_BITS'(-$urandom_range(1, 128));
    endcase
  endfunction

  initial begin
    int                           n;
    int                           seg_left;
    bit                           fresh;
    mode_t                        m;
    logic [DROP_BITS-1:0]         drop;
    logic signed [SCORE_BITS-1:0] tgt;
    logic signed [PS_BITS-1:0]    ps;
    logic                         lst;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings out of reset: X-drop with no slack; last is ignored here
    queue_item(127, 1'b0);
    queue_item(-128, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(5, 1'b1);
    queue_item(0, 1'b0);
    queue_item(-128, 1'b1);
    wait_idle();

    // Widest slack: deep drops without an end, state carried into the next mode
    set_config(MODE_XDROP, '1, '0);
    queue_item(-128, 1'b0);
    queue_item(127, 1'b0);
    queue_item(-128, 1'b0);
    wait_idle();

    // End search: zero target ends at once, then a reachable, a lowest and a highest target
    set_config(MODE_END_SEARCH, '0, '0);
    queue_item(3, 1'b1);
    wait_idle();
    set_config(MODE_END_SEARCH, '0, 24'sd5);
    queue_item(3, 1'b0);
    queue_item(3, 1'b0);
    wait_idle();
    set_config(MODE_END_SEARCH, '0, {1'b1, {(SCORE_BITS-1){1'b0}}});
    queue_item(-128, 1'b0);
    wait_idle();
    set_config(MODE_END_SEARCH, '0, {1'b0, {(SCORE_BITS-1){1'b1}}});
    queue_item(127, 1'b0);
    queue_item(1, 1'b0);
    wait_idle();

    // Plain sum, picking up the sum left open above
    set_config(MODE_SUM, '0, '0);
    queue_item(1, 1'b0);
    queue_item(2, 1'b0);
    queue_item(3, 1'b1);
    queue_item(-128, 1'b0);
    queue_item(127, 1'b1);
    wait_idle();

    // Optimality: excessive drop, rising last, non-positive prefix, flat last
    set_config(MODE_OPT_CHECK, 23'd2, '0);
    queue_item(5, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(-3, 1'b0);
    queue_item(3, 1'b0);
    queue_item(2, 1'b1);
    queue_item(-1, 1'b0);
    queue_item(4, 1'b0);
    queue_item(0, 1'b1);
    wait_idle();

    // Random phases; each drains before the next setting
    for (int c = 0; c < 12; c++) begin
      calm <= (c == 6);
      m = mode_t'($urandom_range(3));
      drop = DROP_BITS'($urandom_range(0, (m == MODE_OPT_CHECK) ? 60 : 400));
      tgt = SCORE_BITS'($urandom_range(1, 600));
      case ($urandom_range(7))
        0: begin
          drop = '0;
          tgt = '0;
        end
        1: begin
          drop = '1;
          tgt = {1'b1, {(SCORE_BITS-1){1'b0}}};
        end
        2: begin
          drop = DROP_BITS'($urandom());
          tgt = {1'b0, {(SCORE_BITS-1){1'b1}}};
        end
        3: tgt = SCORE_BITS'(-$urandom_range(1, 600));
        default: ;
      endcase
      set_config(m, drop, tgt);
      n = $urandom_range(60, 90);
      seg_left = 0;
      for (int k = 0; k < n; k++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 12);
          fresh = 1'b1;
        end else begin
          fresh = 1'b0;
        end
        ps = rand_score();
        if (m == MODE_END_SEARCH && $urandom_range(9) < 7) ps = PS_BITS'($urandom_range(0, 127));
        if (m == MODE_OPT_CHECK && fresh && $urandom_range(9) != 0)
          ps = PS_BITS'($urandom_range(1, 127));
        lst = (seg_left == 1);
        if (m == MODE_XDROP || m == MODE_END_SEARCH || $urandom_range(9) == 0)
          lst = 1'($urandom_range(1));
        seg_left--;
        queue_item(int'(ps), lst);
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (faults == 0 && predicted.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
